// ----- hw/rtl/sha256_pkg.sv -----
package sha256_pkg;

	// request codes
	localparam logic [1:0] REQ_ABSORB = 2'd0;
	localparam logic [1:0] REQ_ABSORB_FINISH = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;

	// one byte operation handed from the front part to the core
	typedef struct packed {
		logic [7:0] data;
		logic       compress;   // this byte completes a block
		logic       emit;       // digest out after this byte
	} byte_op_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_CHAIN [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- hw/rtl/sha256_hasher_top.sv -----
// streaming sha-256 over a byte message
// input channel: push/full with req_type and data_byte; absorb adds one
// byte, absorb-finish adds a byte then pads, finish pads only; code 3
// is dropped without effect
// result channel: empty/pop; after a finish eight digest words come out,
// word_index 0..7, last_word set on the eighth
// throughput: one byte per cycle into the block buffer while the core fills;
// every 64th byte starts the rounds of the single round engine, during which
// the core stalls and the 4-entry byte queue fills before full rises
// on a finish the padding bytes (marker, zeros, bit length) go in, then one
// or two compressions run and the digest is shown at once
// a stalled receiver holds the digest; no new bytes enter the core until
// all eight words have been transferred
// reset returns the chain to the initial hash and clears all counts
module sha256_hasher_top import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	logic     f_valid, f_ready, c_valid, c_ready;
	byte_op_t f_op, c_op;

	sha256_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.req_type(req_type), .data_byte(data_byte),
		.op_valid(f_valid), .op_ready(f_ready), .op(f_op)
	);

	sha256_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_ready(f_ready),
		.in_op(f_op), .out_valid(c_valid), .out_ready(c_ready), .out_op(c_op)
	);

	sha256_core u_core (
		.clk(clk), .arst_n(arst_n), .op_valid(c_valid), .op_ready(c_ready),
		.op(c_op), .empty(empty), .pop(pop), .digest_word(digest_word),
		.word_index(word_index), .last_word(last_word)
	);

endmodule

// ----- hw/rtl/sha256_front.sv -----
// front part: turns requests into a byte stream with padding
module sha256_front import sha256_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] req_type,
	input  logic [7:0] data_byte,
	output logic       op_valid,
	input  logic       op_ready,
	output byte_op_t   op
);

	typedef enum logic [2:0] {
		ST_TAKE = 3'b001,
		ST_ZERO = 3'b010,
		ST_LEN  = 3'b100
	} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [60:0] bytes_q;
	logic [63:0] bits_q;
	logic [2:0]  len_idx_q;
	logic        pad_first_q;   // marker byte still owed

	logic        take;
	logic        real_req;
	logic [60:0] bytes_next;

	assign real_req = (req_type == REQ_ABSORB) || (req_type == REQ_ABSORB_FINISH)
		|| (req_type == REQ_FINISH);
	assign full = (state_q != ST_TAKE) || !op_ready;
	assign take = push && !full;
	assign bytes_next = bytes_q + 61'd1;

	// byte produced this cycle
	always_comb begin
		op_valid = 1'b0;
		op.data = 8'h00;
		unique case (state_q)
			ST_TAKE: begin
				if (take && req_type != REQ_FINISH && real_req) begin
					op_valid = 1'b1;
					op.data = data_byte;
				end else if (take && req_type == REQ_FINISH) begin
					op_valid = 1'b1;
					op.data = PAD_MARK;
				end
			end
			ST_ZERO: begin
				op_valid = 1'b1;
				op.data = pad_first_q ? PAD_MARK : 8'h00;
			end
			ST_LEN: begin
				op_valid = 1'b1;
				op.data = bits_q[63:56];
			end
			default: ;
		endcase
		op.compress = (fill_q == 6'd63);
		op.emit = (state_q == ST_LEN) && (len_idx_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TAKE;
			fill_q <= '0;
			bytes_q <= '0;
			pad_first_q <= 1'b0;
			len_idx_q <= '0;
			bits_q <= '0;
		end else begin
			if (op_valid && op_ready)
				fill_q <= fill_q + 6'd1;
			unique case (state_q)
				ST_TAKE: begin
					if (take && real_req) begin
						if (req_type != REQ_FINISH)
							bytes_q <= bytes_next;
						if (req_type == REQ_ABSORB_FINISH) begin
							state_q <= ST_ZERO;
							pad_first_q <= 1'b1;
							bits_q <= {bytes_next, 3'b000};
						end else if (req_type == REQ_FINISH) begin
							bits_q <= {bytes_q, 3'b000};
							pad_first_q <= 1'b0;
							state_q <= (fill_q == LEN_START - 6'd1) ? ST_LEN : ST_ZERO;
							len_idx_q <= '0;
						end
					end
				end
				ST_ZERO: begin
					if (op_ready) begin
						pad_first_q <= 1'b0;
						if (fill_q == LEN_START - 6'd1) begin
							state_q <= ST_LEN;
							len_idx_q <= '0;
						end
					end
				end
				ST_LEN: begin
					if (op_ready) begin
						bits_q <= {bits_q[55:0], 8'h00};
						len_idx_q <= len_idx_q + 3'd1;
						if (len_idx_q == 3'd7) begin
							state_q <= ST_TAKE;
							bytes_q <= '0;
						end
					end
				end
				default: state_q <= ST_TAKE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/sha256_fifo.sv -----
// short queue between front and core
module sha256_fifo import sha256_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  byte_op_t in_op,
	output logic     out_valid,
	input  logic     out_ready,
	output byte_op_t out_op
);

	byte_op_t   mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       wr_en;
	logic       rd_en;

	assign in_ready = (cnt_q != 3'd4);
	assign out_valid = (cnt_q != 3'd0);
	assign out_op = mem_q[rd_q];
	assign wr_en = in_valid && in_ready;
	assign rd_en = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_q] <= in_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wr_q <= wr_q + 2'd1;
			if (rd_en)
				rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'b00, wr_en} - {2'b00, rd_en};
		end
	end

endmodule

// ----- hw/rtl/sha256_core.sv -----
// back part: block buffer, round engine and digest output queue
module sha256_core import sha256_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	output logic        op_ready,
	input  byte_op_t    op,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	typedef enum logic [2:0] {
		ST_FILL  = 3'b001,
		ST_ROUND = 3'b010,
		ST_OUT   = 3'b100
	} state_t;

	state_t      state_q;
	logic [31:0] w_q [16];      // schedule window, doubles as block buffer
	logic [31:0] chain_q [8];
	logic [31:0] v_q [8];
	logic [5:0]  rnd_q;
	logic        emit_q;
	logic [2:0]  out_idx_q;

	logic [31:0] s0, s1, w_new, t1, t2, ch, mj;
	logic        take;

	assign take = op_valid && op_ready;
	assign op_ready = (state_q == ST_FILL);
	assign empty = (state_q != ST_OUT);
	assign digest_word = chain_q[out_idx_q];
	assign word_index = out_idx_q;
	assign last_word = (out_idx_q == 3'd7);

	// round datapath
	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
			+ ch + ROUND_K[rnd_q] + w_q[0];
		t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) + mj;
	end

	always_ff @(posedge clk) begin
		// bytes shift in big-endian; window shifts one word per round
		if (take) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
			w_q[15] <= {w_q[15][23:0], op.data};
		end else if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			for (int i = 0; i < 8; i++) begin
				chain_q[i] <= INIT_CHAIN[i];
				v_q[i] <= INIT_CHAIN[i];
			end
			rnd_q <= '0;
			emit_q <= 1'b0;
			out_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (take && op.compress) begin
						state_q <= ST_ROUND;
						rnd_q <= '0;
						emit_q <= op.emit;
						for (int i = 0; i < 8; i++)
							v_q[i] <= chain_q[i];
					end
				end
				ST_ROUND: begin
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						// fold the last round's working words into the chain
						chain_q[0] <= chain_q[0] + t1 + t2;
						for (int i = 1; i < 4; i++)
							chain_q[i] <= chain_q[i] + v_q[i-1];
						chain_q[4] <= chain_q[4] + v_q[3] + t1;
						for (int i = 5; i < 8; i++)
							chain_q[i] <= chain_q[i] + v_q[i-1];
						state_q <= emit_q ? ST_OUT : ST_FILL;
						out_idx_q <= '0;
					end
				end
				ST_OUT: begin
					if (pop) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							state_q <= ST_FILL;
							for (int i = 0; i < 8; i++)
								chain_q[i] <= INIT_CHAIN[i];
						end
					end
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

endmodule
